// ===== rtl/fusf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fusf_pkg: shared definitions of the first unique symbol finder
// Sizes of the symbol store, its entry layout and the control structures that
// pass between the sequencer and the store.
// ----------------------------------------------------------------------------
package fusf_pkg;

   // Alphabet and string limits.
   localparam int ALPHABET_SIZE = 128;
   localparam int MAX_LENGTH    = 65535;

   // Field widths.
   localparam int SYM_W  = 7;
   localparam int POS_W  = 16;
   localparam int CNT_W  = 2;
   localparam int ADDR_W = $clog2(ALPHABET_SIZE);

   // Saturation value of an occurrence count.
   localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

   // One entry of the symbol store.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [POS_W-1:0] position;
   } entry_type;

   // Requests from the sequencer to the store.
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_entry;
   } store_req_type;

   // Registered read data from the store.
   typedef struct packed {
      entry_type entry;
   } store_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/first_unique_symbol_finder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_unique_symbol_finder_unit: earliest symbol that occurs exactly once
// Counts the symbols of a zero-terminated string and, on the terminator,
// returns the earliest symbol that occurred exactly once.
// ----------------------------------------------------------------------------
// Symbols arrive one per item on the req_ channel; a zero symbol ends the
// string and produces exactly one item on the rsp_ channel, other symbols
// produce none. Each non-zero symbol is handled as a read and then a write back
// of its entry in the single-port-per-direction symbol store. The terminator
// starts a scan that reads the store one entry per cycle, from symbol 1 up to
// ALPHABET_SIZE - 1, then passes through the drain and finish states, and waits
// in the finish state for the previous result to be taken. The result sits in an
// output register, so the next string may start while it waits. Counts
// saturate at three; a string longer than MAX_LENGTH symbols sets the
// overflow flag and the other result fields are then unreliable.
// ----------------------------------------------------------------------------
module first_unique_symbol_finder_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [fusf_pkg::SYM_W-1:0] req_symbol,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [fusf_pkg::SYM_W-1:0] rsp_unique_symbol,
   output logic                       rsp_overflow
);
   import fusf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sym_ff, sym_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0] cmp_addr_ff, cmp_addr_in;
   logic              have_ff, have_in;
   logic [ADDR_W-1:0] best_sym_ff, best_sym_in;
   logic [POS_W-1:0]  best_pos_ff, best_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SYM_W-1:0]  rsp_sym_ff, rsp_sym_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   store_req_type     store_req;
   store_rsp_type     store_rsp;
   logic              req_take;
   logic              in_alphabet;
   logic              out_free;
   logic [CNT_W-1:0]  cnt_next;

   fusf_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (store_req),
      .rsp   (store_rsp)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_take    = req_valid && req_ready;
   assign in_alphabet = ({1'b0, req_symbol} < (SYM_W+1)'(ALPHABET_SIZE));
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Saturating increment of the count that was read.
   assign cnt_next = (store_rsp.entry.count == COUNT_MAX) ? COUNT_MAX
                                                          : store_rsp.entry.count + 1'b1;

   // Sequencer: update on symbols, scan and report on the terminator.
   always_comb begin
      state_in     = state_ff;
      sym_in       = sym_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      cmp_addr_in  = cmp_addr_ff;
      have_in      = have_ff;
      best_sym_in  = best_sym_ff;
      best_pos_in  = best_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      store_req          = '0;
      store_req.wr_addr  = sym_ff;
      store_req.rd_addr  = ADDR_W'(req_symbol);

      // Running minimum over entries read during the scan.
      if (cmp_valid_ff && store_rsp.entry.count == CNT_W'(1)) begin
         if (!have_ff || store_rsp.entry.position < best_pos_ff) begin
            have_in     = 1'b1;
            best_sym_in = cmp_addr_ff;
            best_pos_in = store_rsp.entry.position;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_symbol == '0) begin
                  scan_in     = ADDR_W'(1);
                  have_in     = 1'b0;
                  best_sym_in = '0;
                  best_pos_in = '0;
                  state_in    = ST_SCAN;
               end else if (in_alphabet) begin
                  store_req.rd_en = 1'b1;
                  sym_in          = ADDR_W'(req_symbol);
                  state_in        = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            store_req.wr_en          = 1'b1;
            store_req.wr_entry.count = cnt_next;
            store_req.wr_entry.position = (store_rsp.entry.count == '0)
                                          ? pos_ff : store_rsp.entry.position;
            if (pos_ff == POS_W'(MAX_LENGTH)) begin
               ovf_in = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = scan_ff;
            cmp_valid_in      = 1'b1;
            cmp_addr_in       = scan_ff;
            scan_in           = scan_ff + 1'b1;
            if (scan_ff == ADDR_W'(ALPHABET_SIZE - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = have_ff;
               rsp_sym_in      = SYM_W'(best_sym_ff);
               rsp_ovf_in      = ovf_ff;
               store_req.clear = 1'b1;
               pos_in          = '0;
               ovf_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      scan_ff      <= scan_in;
      cmp_addr_ff  <= cmp_addr_in;
      have_ff      <= have_in;
      best_sym_ff  <= best_sym_in;
      best_pos_ff  <= best_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_unique_symbol = rsp_sym_ff;
   assign rsp_overflow      = rsp_ovf_ff;

   // A new result only appears as the sequencer leaves its finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result item raised outside the finish state");

   // The overflow flag is only ever set with the position counter pinned.
   a_ovf_pos: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pos_ff == POS_W'(MAX_LENGTH)))
      else $error("overflow flag set below the maximum length");

   // Handing out a result clears the string state for the next string.
   a_clear_on_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (pos_ff == '0 && !ovf_ff && state_ff == ST_IDLE))
      else $error("string state not cleared with the result");

endmodule
`default_nettype wire

// ===== rtl/fusf_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fusf_store: symbol store of the first unique symbol finder
// One synchronous memory of count and first position per symbol, with a
// registered read port, plus a valid bit per entry so that a whole string can
// be forgotten with a single clear request.
// ----------------------------------------------------------------------------
module fusf_store (
   input  logic                    clock,
   input  logic                    reset,
   input  fusf_pkg::store_req_type req,
   output fusf_pkg::store_rsp_type rsp
);
   import fusf_pkg::*;

   entry_type                mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   entry_type                rd_entry_ff;
   logic                     rd_valid_ff;

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_entry;
      end
      if (req.rd_en) begin
         rd_entry_ff <= mem[req.rd_addr];
      end
   end

   // Valid bits: an entry not written since the last clear reads as a zero count.
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   // Gate the count with the valid bit; the position is only used when valid.
   always_comb begin
      rsp.entry.count    = rd_valid_ff ? rd_entry_ff.count : '0;
      rsp.entry.position = rd_entry_ff.position;
   end

endmodule
`default_nettype wire

// ===== tb/tb_first_unique_symbol_finder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_first_unique_symbol_finder_unit: self-checking bench for the finder
// Streams zero-terminated strings into the block and predicts the answer to
// each terminator. Every returned item is compared field by field with the
// oldest prediction. The run covers short directed strings and random strings
// under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_first_unique_symbol_finder_unit;
   import fusf_pkg::*;

   // Predicted content of one result item.
   typedef struct {
      logic             found;
      logic [SYM_W-1:0] symbol;
      logic             overflow;
   } finder_answer_type;

   // Short strings that cover the empty string, the largest symbol, repeats,
   // saturation of the count and the choice of the earliest unique symbol.
   localparam logic [SYM_W-1:0] OPENING_STRINGS [22] = '{
      7'd0,
      7'd127, 7'd0,
      7'd1, 7'd1, 7'd0,
      7'd5, 7'd5, 7'd5, 7'd5, 7'd0,
      7'd3, 7'd1, 7'd3, 7'd2, 7'd0,
      7'd126, 7'd64, 7'd63, 7'd64, 7'd126, 7'd0
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [SYM_W-1:0] req_symbol = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic [SYM_W-1:0] rsp_unique_symbol;
   logic             rsp_overflow;

   // Symbols still to be sent and answers still to be returned.
   logic [SYM_W-1:0]  symbol_backlog [$];
   finder_answer_type answer_queue [$];

   // Shadow copy of the symbol store.
   logic [CNT_W-1:0] sym_count [ALPHABET_SIZE];
   logic [POS_W-1:0] first_pos [ALPHABET_SIZE];
   logic [POS_W-1:0] str_pos;
   logic             str_overflow;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int queued_items = 0;
   int error_count = 0;

   first_unique_symbol_finder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_unique_symbol (rsp_unique_symbol),
      .rsp_overflow      (rsp_overflow)
   );

   // Clock with a period of four units.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Forget the current string: counts, position and overflow return to zero.
   function automatic void forget_string();
      foreach (sym_count[s]) sym_count[s] = '0;
      str_pos = '0;
      str_overflow = 1'b0;
   endfunction

   // Update the shadow store with one accepted symbol; a terminator yields
   // the predicted answer for the string.
   function automatic void note_symbol(input logic [SYM_W-1:0] sym);
      finder_answer_type answer;
      logic [POS_W-1:0]  best_pos;
      answer.found = 1'b0;
      answer.symbol = '0;
      best_pos = '0;
      if (sym != '0) begin
         if (str_pos >= MAX_LENGTH) begin
            str_overflow = 1'b1;
            str_pos = POS_W'(MAX_LENGTH);
         end
         if (sym_count[sym] == '0) first_pos[sym] = str_pos;
         if (sym_count[sym] != COUNT_MAX) sym_count[sym] = sym_count[sym] + 1'b1;
         if (str_pos < MAX_LENGTH) str_pos = str_pos + 1'b1;
      end else begin
         // Scan upwards, so that on equal positions the smaller symbol wins.
         for (int s = 1; s < ALPHABET_SIZE; s++) begin
            if (sym_count[s] == 1 && (!answer.found || first_pos[s] < best_pos)) begin
               answer.found = 1'b1;
               answer.symbol = s[SYM_W-1:0];
               best_pos = first_pos[s];
            end
         end
         answer.overflow = str_overflow;
         answer_queue.push_back(answer);
         forget_string();
      end
   endfunction

   function automatic void check_field(input string name, input logic [SYM_W-1:0] want,
                                       input logic [SYM_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Driver: offers the next symbol once the previous item has gone, with
   // random gaps, and toggles the result ready at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_ready) begin
            if (symbol_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_symbol <= symbol_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: checks each returned item, then feeds each accepted symbol to
   // the predictor.
   always @(posedge clock) begin
      finder_answer_type want;
      if (reset) begin
         forget_string();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               $error("result item with no string waiting for an answer");
               error_count++;
            end else begin
               want = answer_queue.pop_front();
               check_field("found", SYM_W'(want.found), SYM_W'(rsp_found));
               check_field("unique_symbol", want.symbol, rsp_unique_symbol);
               check_field("overflow", SYM_W'(want.overflow), SYM_W'(rsp_overflow));
            end
         end
         if (req_valid && req_ready) note_symbol(req_symbol);
      end
   end

   // A random string; mostly short and over a narrow range of symbols so
   // that repeats are common, now and then long or over the full range.
   task automatic add_random_string();
      int len;
      int span;
      int base;
      len = ($urandom_range(9) < 8) ? $urandom_range(12, 0) : $urandom_range(60, 13);
      span = ($urandom_range(3) == 0) ? 127 : $urandom_range(10, 1);
      base = $urandom_range(128 - span, 1);
      for (int i = 0; i < len; i++) begin
         symbol_backlog.push_back(SYM_W'(base + $urandom_range(span - 1, 0)));
      end
      symbol_backlog.push_back('0);
      queued_items += len + 1;
   endtask

   // Wait until every symbol has been sent and every predicted answer has come back.
   task automatic wait_all_answered();
      while (symbol_backlog.size() != 0 || req_valid || answer_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Stimulus, in three phases of back-pressure.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Sender seldom idle, receiver often stalled.
      send_idle_pct = 6;
      recv_stall_pct = 45;
      foreach (OPENING_STRINGS[i]) symbol_backlog.push_back(OPENING_STRINGS[i]);
      queued_items = 0;
      while (queued_items < 270) add_random_string();
      wait_all_answered();

      // Roles swapped.
      send_idle_pct = 45;
      recv_stall_pct = 6;
      queued_items = 0;
      while (queued_items < 270) add_random_string();
      wait_all_answered();

      // No idling.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queued_items = 0;
      while (queued_items < 40) add_random_string();
      wait_all_answered();

      // Allow for a late stray item from the table scan.
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
